### rtl/lzwse_pkg.sv
// Shared types and constants of the LZW stream encoder.
// Request and result structs, code constants. No dependencies.
package lzwse_pkg;

	// width of an emitted code and size of the byte alphabet
	localparam int CODE_BITS  = 12;
	localparam int ALPHA_SIZE = 256;

	// terminate code that closes every stream
	localparam logic [CODE_BITS-1:0] TERM_CODE = CODE_BITS'(ALPHA_SIZE);

	// generation tag width for dictionary entries
	localparam int EPOCH_BITS = 4;

	// one input request: a byte and the end of stream flag
	typedef struct packed {
		logic [7:0] data_byte;
		logic       final_byte;
	} in_item_t;

	// one result: code plus framing flags
	typedef struct packed {
		logic [CODE_BITS-1:0] code_word;
		logic                 last_of_run;
		logic                 stream_done;
	} out_item_t;

endpackage

### rtl/lzwse_out_fifo.sv
// Small result queue between the encoder engine and the output channel.
// Depends on lzwse_pkg for the result struct.
module lzwse_out_fifo
	import lzwse_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  out_item_t push_item,
	output logic      full,
	output logic      code_valid,
	input  logic      code_stall,
	output out_item_t code
);

	localparam int DEPTH = 4;
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	out_item_t          slot_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               pop;

	// status and read side
	assign full       = (count_q == CNT_FULL);
	assign code_valid = (count_q != '0);
	assign code       = slot_q[rd_ptr_q];
	assign pop        = code_valid && !code_stall;

	// pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_FULL)
		else $error("result queue occupancy out of range");

	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (count_q == $past(count_q) + 1'b1))
		else $error("result queue did not grow on push");

	a_count_down: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !push) |=> (count_q == $past(count_q) - 1'b1))
		else $error("result queue did not shrink on pop");

endmodule

### rtl/lzwse_engine.sv
// Dictionary engine: hashed string table in one synchronous RAM, probing
// state machine and result sequencing. Depends on lzwse_pkg.
module lzwse_engine
	import lzwse_pkg::*;
#(
	parameter int TABLE_CODES = 4096
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      data_valid,
	output logic      data_stall,
	input  in_item_t  data,
	output logic      push,
	output out_item_t res,
	input  logic      fifo_full
);

	localparam int IDX_W = $clog2(TABLE_CODES);
	localparam logic [IDX_W-1:0] SLOT_LAST  = '1;
	localparam logic [IDX_W:0]   TBL_LIM    = (IDX_W+1)'(TABLE_CODES);
	localparam logic [IDX_W:0]   FIRST_FREE = (IDX_W+1)'(ALPHA_SIZE + 1);
	localparam logic [EPOCH_BITS-1:0] EPOCH_LAST = '1;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_PROBE,
		ST_EMIT_MISS,
		ST_EMIT_PFX,
		ST_EMIT_TERM
	} state_t;

	// one hashed slot: a learned pair and the code it was given
	typedef struct packed {
		logic                  vld;
		logic [EPOCH_BITS-1:0] epoch;
		logic [IDX_W-1:0]      prefix;
		logic [7:0]            chr;
		logic [IDX_W-1:0]      code;
	} dent_t;

	dent_t dict_mem [2**IDX_W];
	dent_t rdata_q;

	state_t                 state_q;
	logic [IDX_W-1:0]       prefix_q;
	logic                   present_q;
	logic [IDX_W:0]         nxt_q;
	logic [EPOCH_BITS-1:0]  epoch_q;
	logic [IDX_W-1:0]       clr_q;
	logic [7:0]             byte_q;
	logic                   fin_q;
	logic [IDX_W-1:0]       slot_q;
	logic [IDX_W-1:0]       miss_q;

	logic                   accept;
	logic [IDX_W-1:0]       hash;
	logic                   live;
	logic                   match;
	logic                   room;
	logic                   mem_re;
	logic [IDX_W-1:0]       mem_ra;
	logic                   mem_we;
	logic [IDX_W-1:0]       mem_wa;
	dent_t                  mem_wd;

	// zero-extend or truncate an internal code to the output width
	function automatic logic [CODE_BITS-1:0] to_code(input logic [IDX_W-1:0] c);
		logic [IDX_W+CODE_BITS-1:0] w;
		w = {{CODE_BITS{1'b0}}, c};
		return w[CODE_BITS-1:0];
	endfunction

	// handshake and lookup helpers
	assign data_stall = (state_q != ST_IDLE);
	assign accept     = data_valid && (state_q == ST_IDLE);
	assign hash       = prefix_q ^ {data.data_byte, {(IDX_W-8){1'b0}}};
	assign live       = rdata_q.vld && (rdata_q.epoch == epoch_q);
	assign match      = (rdata_q.prefix == prefix_q) && (rdata_q.chr == byte_q);
	assign room       = (nxt_q < TBL_LIM);

	// memory port control
	always_comb begin
		mem_re = 1'b0;
		mem_ra = hash;
		mem_we = 1'b0;
		mem_wa = clr_q;
		mem_wd = '0;
		unique case (state_q)
			ST_CLEAR: begin
				mem_we = 1'b1;
			end
			ST_IDLE: begin
				mem_re = accept && present_q;
			end
			ST_PROBE: begin
				mem_re = live && !match;
				mem_ra = slot_q + 1'b1;
				mem_we = !live && room;
				mem_wa = slot_q;
				mem_wd = '{vld: 1'b1, epoch: epoch_q, prefix: prefix_q, chr: byte_q,
					code: nxt_q[IDX_W-1:0]};
			end
			default: begin
			end
		endcase
	end

	// dictionary ram, one read and one write port, registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			dict_mem[mem_wa] <= mem_wd;
		end
		if (mem_re) begin
			rdata_q <= dict_mem[mem_ra];
		end
	end

	// result selection
	always_comb begin
		push = 1'b0;
		res  = '{code_word: TERM_CODE, last_of_run: 1'b1, stream_done: 1'b1};
		unique case (state_q)
			ST_EMIT_MISS: begin
				push = !fifo_full;
				res  = '{code_word: to_code(miss_q), last_of_run: !fin_q, stream_done: 1'b0};
			end
			ST_EMIT_PFX: begin
				push = !fifo_full;
				res  = '{code_word: to_code(prefix_q), last_of_run: 1'b0, stream_done: 1'b0};
			end
			ST_EMIT_TERM: begin
				push = !fifo_full;
			end
			default: begin
			end
		endcase
	end

	// control state machine
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_q     <= '0;
			epoch_q   <= '0;
			present_q <= 1'b0;
			prefix_q  <= '0;
			nxt_q     <= FIRST_FREE;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == SLOT_LAST) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						if (!present_q) begin
							prefix_q  <= {{(IDX_W-8){1'b0}}, data.data_byte};
							present_q <= 1'b1;
							state_q   <= data.final_byte ? ST_EMIT_PFX : ST_IDLE;
						end else begin
							state_q <= ST_PROBE;
						end
					end
				end
				ST_PROBE: begin
					if (live && match) begin
						prefix_q <= rdata_q.code;
						state_q  <= fin_q ? ST_EMIT_PFX : ST_IDLE;
					end else if (!live) begin
						if (room) begin
							nxt_q <= nxt_q + 1'b1;
						end
						prefix_q <= {{(IDX_W-8){1'b0}}, byte_q};
						state_q  <= ST_EMIT_MISS;
					end
				end
				ST_EMIT_MISS: begin
					if (!fifo_full) begin
						state_q <= fin_q ? ST_EMIT_PFX : ST_IDLE;
					end
				end
				ST_EMIT_PFX: begin
					if (!fifo_full) begin
						state_q <= ST_EMIT_TERM;
					end
				end
				ST_EMIT_TERM: begin
					if (!fifo_full) begin
						present_q <= 1'b0;
						prefix_q  <= '0;
						nxt_q     <= FIRST_FREE;
						epoch_q   <= epoch_q + 1'b1;
						state_q   <= (epoch_q == EPOCH_LAST) ? ST_CLEAR : ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_CLEAR;
				end
			endcase
		end
	end

	// per-request working registers
	always_ff @(posedge clk) begin
		if (accept) begin
			byte_q <= data.data_byte;
			fin_q  <= data.final_byte;
			slot_q <= hash;
		end
		if (state_q == ST_PROBE) begin
			if (live && !match) begin
				slot_q <= slot_q + 1'b1;
			end
			if (!live) begin
				miss_q <= prefix_q;
			end
		end
	end

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !fifo_full)
		else $error("result pushed into a full queue");

	a_free_bound: assert property (@(posedge clk) disable iff (!arst_n)
		nxt_q <= TBL_LIM)
		else $error("next free code ran past the table");

	a_hit_learned: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PROBE && live && match) |-> ({1'b0, rdata_q.code} >= FIRST_FREE))
		else $error("dictionary hit returned a code below the learned range");

	a_term_resets: assert property (@(posedge clk) disable iff (!arst_n)
		(push && res.stream_done) |=> (!present_q && nxt_q == FIRST_FREE))
		else $error("stream state not cleared after terminate code");

endmodule

### rtl/lzw_stream_encoder_core.sv
// LZW stream encoder, fixed-width codes: top level.
// Depends on lzwse_pkg, lzwse_engine and lzwse_out_fifo.
//
// Takes one byte per request and emits dictionary codes; the final byte of a
// stream flushes the pending prefix and then the terminate code 256, and the
// dictionary starts over. Learned pairs live in a hashed, linearly probed RAM
// of 2**clog2(TABLE_CODES) slots with a registered read. A byte that starts a
// stream is taken in idle; one that extends the current match also passes the
// probe state, one that ends a match then the emit state for its code; the
// probe steps past each occupied slot, and the final byte adds the flush and
// terminate codes. One byte is worked on at a time, since each lookup needs
// the prefix left by the one before. Results go through a four-entry queue,
// so the output side may stall without holding up input until it fills.
// Entries carry a 4-bit stream tag, so ending a stream needs no table sweep,
// except after every 16th stream and after reset, when a clearing pass over
// all 2**clog2(TABLE_CODES) slots (4096 by default) runs with data_stall high.
module lzw_stream_encoder_core
	import lzwse_pkg::*;
#(
	parameter int TABLE_CODES = 4096
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      data_valid,
	output logic      data_stall,
	input  in_item_t  data,
	output logic      code_valid,
	input  logic      code_stall,
	output out_item_t code
);

	logic      push;
	out_item_t res;
	logic      fifo_full;

	// dictionary engine
	lzwse_engine #(
		.TABLE_CODES(TABLE_CODES)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.data_valid(data_valid),
		.data_stall(data_stall),
		.data      (data),
		.push      (push),
		.res       (res),
		.fifo_full (fifo_full)
	);

	// result queue toward the output channel
	lzwse_out_fifo u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (res),
		.full      (fifo_full),
		.code_valid(code_valid),
		.code_stall(code_stall),
		.code      (code)
	);

endmodule
